// ===== rtl/core/faq_pkg.sv =====
// Shared types and codes for the fraction arithmetic unit.
`default_nettype none
package faq_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_MUL  = 3'd1,
    OP_EQ   = 3'd2,
    OP_INC  = 3'd3,
    OP_SIMP = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic eq;
    logic reduce;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/faq_front.sv =====
// Front end: accepts items, forms the raw products and classifies the result.
`default_nettype none
module faq_front import faq_pkg::*; #(
  parameter int W = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [2:0]               operation_i,
  input  wire  signed [W-1:0]      a_numerator_i,
  input  wire  [W-2:0]             a_denominator_i,
  input  wire  signed [W-1:0]      b_numerator_i,
  input  wire  [W-2:0]             b_denominator_i,
  input  wire                      full_i,
  output logic                     push_o,
  output logic signed [2*W-1:0]    rn_o,
  output logic [2*W-3:0]           rd_o,
  output ctl_t                     ctl_o
);
  localparam int NW = 2 * W;

  logic                 valid_q, valid_d;
  logic [2:0]           op_q;
  logic signed [NW-1:0] p_bd_an_q, p_ad_bn_q;
  logic [NW-3:0]        p_ad_bd_q;
  logic signed [W-1:0]  an_q;
  logic [W-2:0]         ad_q;
  logic                 eq_q;
  logic signed [W-1:0]  ad_s, bd_s;
  logic signed [W-1:0]  mul_b;
  logic                 accept;
  logic                 red_op;

  assign ad_s = {1'b0, a_denominator_i};
  assign bd_s = {1'b0, b_denominator_i};

  // Multiply places a_num * b_num in the first cross product slot.
  assign mul_b = (operation_i == OP_MUL) ? b_numerator_i : bd_s;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      p_bd_an_q <= NW'(a_numerator_i) * NW'(mul_b);
      p_ad_bn_q <= NW'(ad_s) * NW'(b_numerator_i);
      p_ad_bd_q <= (NW-2)'(a_denominator_i) * (NW-2)'(b_denominator_i);
      an_q      <= a_numerator_i;
      ad_q      <= a_denominator_i;
      eq_q      <= (a_numerator_i == b_numerator_i) &&
                   (a_denominator_i == b_denominator_i);
    end
  end

  always_comb begin
    rn_o   = '0;
    rd_o   = '0;
    red_op = 1'b1;
    ctl_o.eq = 1'b0;
    case (op_q)
      OP_ADD: begin
        rn_o = p_bd_an_q + p_ad_bn_q;
        rd_o = p_ad_bd_q;
      end
      OP_MUL: begin
        rn_o = p_bd_an_q;
        rd_o = p_ad_bd_q;
      end
      OP_EQ: begin
        red_op   = 1'b0;
        ctl_o.eq = eq_q;
      end
      OP_INC: begin
        rn_o = {{W{an_q[W-1]}}, an_q} + {{(W+1){1'b0}}, ad_q};
        rd_o = {{(W-1){1'b0}}, ad_q};
      end
      OP_SIMP: begin
        rn_o = {{W{an_q[W-1]}}, an_q};
        rd_o = {{(W-1){1'b0}}, ad_q};
      end
      default: begin
        red_op = 1'b0;
      end
    endcase
    ctl_o.reduce = red_op && !rn_o[NW-1] && (rn_o != '0) && (rd_o != '0);
  end

endmodule
`default_nettype wire

// ===== rtl/core/faq_fifo.sv =====
// Two-entry queue between the front end and the reduction engine.
`default_nettype none
module faq_fifo #(
  parameter int DW = 8
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  wire  [DW-1:0] data_i,
  input  wire           pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);
  logic [DW-1:0] mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/faq_back.sv =====
// Back end: binary GCD, two bit-serial divisions and the output register.
`default_nettype none
module faq_back import faq_pkg::*; #(
  parameter int W = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    empty_i,
  input  wire  signed [2*W-1:0]  rn_i,
  input  wire  [2*W-3:0]         rd_i,
  input  ctl_t                   ctl_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic signed [2*W-1:0]  res_n_o,
  output logic [2*W-3:0]         res_d_o,
  output logic                   res_eq_o
);
  localparam int NW = 2 * W;
  localparam int VW = NW - 1;
  localparam int CW = $clog2(VW);

  state_e               state_q, state_d;
  logic signed [NW-1:0] n_q;
  logic [VW-1:0]        d_q, x_q, y_q, r2_q;
  logic [CW-1:0]        k_q, cnt_q;
  logic                 eq_q;
  logic                 load;
  logic                 out_valid_q;
  logic [VW:0]          sh_n, sh_d;
  logic                 ge_n, ge_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ctl_i.reduce ? ST_SHIFT : ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (x_q[0] || y_q[0]) begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (x_q == '0) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    case (state_q)
      ST_IDLE: pop_o = !empty_i;
      ST_DONE: load  = !out_valid_q || !out_stall_i;
      default: begin
        pop_o = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The divisor y_q holds the GCD during division; x_q and r2_q are remainders.
  assign sh_n = {x_q, n_q[VW-1]};
  assign sh_d = {r2_q, d_q[VW-1]};
  assign ge_n = (sh_n >= {1'b0, y_q});
  assign ge_d = (sh_d >= {1'b0, y_q});

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          n_q  <= rn_i;
          d_q  <= {1'b0, rd_i};
          x_q  <= rn_i[VW-1:0];
          y_q  <= {1'b0, rd_i};
          k_q  <= '0;
          eq_q <= ctl_i.eq;
        end
      end
      ST_SHIFT: begin
        if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + CW'(1);
        end
      end
      ST_GCD: begin
        if (x_q == '0) begin
          y_q   <= y_q << k_q;
          r2_q  <= '0;
          cnt_q <= CW'(VW - 1);
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
      ST_DIV: begin
        x_q   <= ge_n ? VW'(sh_n - {1'b0, y_q}) : sh_n[VW-1:0];
        r2_q  <= ge_d ? VW'(sh_d - {1'b0, y_q}) : sh_d[VW-1:0];
        n_q   <= {1'b0, n_q[VW-2:0], ge_n};
        d_q   <= {d_q[VW-2:0], ge_d};
        cnt_q <= cnt_q - CW'(1);
      end
      ST_DONE: begin
        if (load) begin
          res_n_o  <= n_q;
          res_d_o  <= d_q[NW-3:0];
          res_eq_o <= eq_q;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/fraction_arithmetic_unit.sv =====
// Top level of the fraction arithmetic unit.
// Usage: present an item on the input channel (in_valid_i with the operation
// and fractions a and b); it transfers on a clock edge where in_stall_o is low.
// Each item yields exactly one result transfer on the output channel, in order.
// Add, multiply, increment and simplify reduce the fraction by its GCD when
// numerator and denominator are both positive; equal compare only sets
// is_equal_o and returns a zero fraction.
// Flow: the front end registers the products and places the item in a
// two-entry queue. The reduction engine sends an item that needs no reduction
// straight from its idle state to its done state; otherwise it removes the
// common factors of two, runs the binary GCD steps and then the bit-serial
// division of both parts. One item is in the engine at a time.
// Reset clears all valid state; no result is pending after reset.
// When the receiver holds out_stall_i high the result stays on the outputs,
// the engine waits, and the queue fills before in_stall_o rises.
`default_nettype none
module fraction_arithmetic_unit import faq_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [2:0]                       operation_i,
  input  wire  signed [OPERAND_WIDTH-1:0]  a_numerator_i,
  input  wire  [OPERAND_WIDTH-2:0]         a_denominator_i,
  input  wire  signed [OPERAND_WIDTH-1:0]  b_numerator_i,
  input  wire  [OPERAND_WIDTH-2:0]         b_denominator_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic signed [31:0]               result_numerator_o,
  output logic [29:0]                      result_denominator_o,
  output logic                             is_equal_o
);
  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * W;
  localparam int EW = NW + (NW - 2) + $bits(ctl_t);

  logic                 push, pop, full, empty;
  logic signed [NW-1:0] f_rn, b_rn, res_n;
  logic [NW-3:0]        f_rd, b_rd, res_d;
  ctl_t                 f_ctl, b_ctl;
  logic [EW-1:0]        q_out;
  logic signed [63:0]   n64;
  logic [63:0]          d64;

  faq_front #(.W(W)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i,
    .a_numerator_i, .a_denominator_i, .b_numerator_i, .b_denominator_i,
    .full_i (full), .push_o(push), .rn_o(f_rn), .rd_o(f_rd), .ctl_o(f_ctl)
  );

  faq_fifo #(.DW(EW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i({f_rn, f_rd, f_ctl}),
    .pop_i(pop), .data_o(q_out), .full_o(full), .empty_o(empty)
  );

  assign {b_rn, b_rd, b_ctl} = q_out;

  faq_back #(.W(W)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .rn_i(b_rn), .rd_i(b_rd), .ctl_i(b_ctl),
    .pop_o(pop), .out_valid_o, .out_stall_i,
    .res_n_o(res_n), .res_d_o(res_d), .res_eq_o(is_equal_o)
  );

  assign n64 = 64'(res_n);
  assign d64 = 64'(res_d);
  assign result_numerator_o   = n64[31:0];
  assign result_denominator_o = d64[29:0];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue read while empty");
  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> result_numerator_o == '0 &&
    result_denominator_o == '0) else $error("compare result carries a fraction");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the fraction arithmetic unit.
`timescale 1ns / 1ps
module tb;
  import faq_pkg::*;

  localparam int W = 16;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [31:0] num;
    logic [29:0]        den;
    logic               eq;
  } fraction_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] operation_i = '0;
  logic signed [W-1:0] a_numerator_i = '0;
  logic [W-2:0] a_denominator_i = '0;
  logic signed [W-1:0] b_numerator_i = '0;
  logic [W-2:0] b_denominator_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] result_numerator_o;
  logic [29:0] result_denominator_o;
  logic is_equal_o;

  fraction_result_t expected_fractions[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  bit idle_enable = 1'b1;

  fraction_arithmetic_unit #(.OPERAND_WIDTH(W)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i,
    .a_numerator_i, .a_denominator_i, .b_numerator_i, .b_denominator_i,
    .out_valid_o, .out_stall_i, .result_numerator_o, .result_denominator_o,
    .is_equal_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_result_t predict_fraction(logic [2:0] op,
      logic signed [W-1:0] an_raw, logic [W-2:0] ad_raw,
      logic signed [W-1:0] bn_raw, logic [W-2:0] bd_raw);
    fraction_result_t r;
    longint an, ad, bn, bd, rn, rd;
    longint unsigned g;
    bit reduce_it;
    an = an_raw;
    bn = bn_raw;
    ad = ad_raw;
    bd = bd_raw;
    rn = 0;
    rd = 0;
    r.eq = 1'b0;
    reduce_it = 1'b1;
    case (op)
      OP_ADD: begin
        rn = bd * an + ad * bn;
        rd = ad * bd;
      end
      OP_MUL: begin
        rn = an * bn;
        rd = ad * bd;
      end
      OP_EQ: begin
        r.eq = (an_raw == bn_raw) && (ad_raw == bd_raw);
        reduce_it = 1'b0;
      end
      OP_INC: begin
        rn = an + ad;
        rd = ad;
      end
      OP_SIMP: begin
        rn = an;
        rd = ad;
      end
      default: reduce_it = 1'b0;
    endcase
    if (reduce_it && rn > 0 && rd > 0) begin
      g = gcd_of(rn, rd);
      rn = rn / longint'(g);
      rd = rd / longint'(g);
    end
    r.num = rn[31:0];
    r.den = rd[29:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
  endtask

  // Sender idle gap; the input stays low during the gap. Valid stays high
  // after the transfer until the next item or an explicit wait drops it.
  task automatic send_fraction_item(logic [2:0] op, logic signed [W-1:0] an,
      logic [W-2:0] ad, logic signed [W-1:0] bn, logic [W-2:0] bd);
    while (idle_enable && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    a_numerator_i <= an;
    a_denominator_i <= ad;
    b_numerator_i <= bn;
    b_denominator_i <= bd;
    expected_fractions.push_back(predict_fraction(op, an, ad, bn, bd));
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Result checker: compares each transfer with the oldest prediction.
  always @(posedge clk_i) begin
    fraction_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_fractions.size() == 0) begin
        report_mismatch("unexpected result", result_numerator_o, 0);
      end else begin
        want = expected_fractions.pop_front();
        if (result_numerator_o !== want.num)
          report_mismatch("numerator", result_numerator_o, want.num);
        if (result_denominator_o !== want.den)
          report_mismatch("denominator", result_denominator_o, want.den);
        if (is_equal_o !== want.eq)
          report_mismatch("is_equal", is_equal_o, want.eq);
      end
    end
    out_stall_i <= idle_enable && ($urandom_range(99) < 38);
  end

  function automatic logic signed [W-1:0] rand_num();
    case ($urandom_range(3))
      0: return W'($urandom_range(40)) - W'(20);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-2:0] rand_den(bit allow_zero);
    logic [W-2:0] d;
    case ($urandom_range(2))
      0: d = (W-1)'($urandom_range(30));
      default: d = (W-1)'($urandom);
    endcase
    if (d == 0 && !allow_zero) d = 1;
    return d;
  endfunction

  task automatic test_directed_extremes();
    logic [2:0] op;
    for (int i = 0; i < 5; i++) begin
      op = 3'(i);
      send_fraction_item(op, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff);
      send_fraction_item(op, 16'sh8000, 15'h7fff, 16'sh8000, 15'd1);
    end
    send_fraction_item(OP_SIMP, 16'sd12, 15'd18, 16'sd0, 15'd1);
    send_fraction_item(OP_SIMP, 16'sd0, 15'd7, 16'sd0, 15'd1);
    send_fraction_item(OP_SIMP, -16'sd12, 15'd18, 16'sd0, 15'd1);
    send_fraction_item(OP_ADD, 16'sd1, 15'd0, 16'sd3, 15'd5);
    send_fraction_item(OP_MUL, 16'sd6, 15'd4, 16'sd2, 15'd3);
    send_fraction_item(OP_INC, -16'sd3, 15'd3, 16'sd0, 15'd1);
    send_fraction_item(OP_EQ, 16'sd5, 15'd9, 16'sd5, 15'd9);
    send_fraction_item(OP_EQ, 16'sd5, 15'd9, 16'sd5, 15'd8);
    send_fraction_item(3'd5, 16'sd5, 15'd9, 16'sd1, 15'd2);
    send_fraction_item(3'd7, 16'sd5, 15'd9, 16'sd1, 15'd2);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random_mix(int count);
    logic [2:0] op;
    logic signed [W-1:0] an;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      an = rand_num();
      if (op == OP_EQ && $urandom_range(1))
        send_fraction_item(op, an, 15'd11, an, ($urandom_range(1) ? 15'd11 : 15'd12));
      else
        send_fraction_item(op, an, rand_den($urandom_range(19) == 0), rand_num(),
                           rand_den($urandom_range(19) == 0));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_random_mix(300);
    wait_for_results();
    idle_enable = 1'b0;
    test_random_mix(150);
    idle_enable = 1'b1;
    test_random_mix(250);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over all five operations and unused codes; checked %0d results.",
             items_sent, results_seen);
    if (mismatch_count == 0 && expected_fractions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", expected_fractions.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
